// ----- src/tun_pkg.sv -----
// shared types and constants for the triangle unit normal block
package tun_pkg;

  localparam int NUM_AXES = 3;

  typedef struct packed {
    logic                valid;
    logic                degenerate;
    logic [NUM_AXES-1:0] neg;
  } ctl_t;

endpackage

// ----- src/tun_setup.sv -----
// setup pipeline: edge vectors, exact cross product, squared length, divider seed
module tun_setup import tun_pkg::*; #(
  parameter int CW = 24,
  parameter int F = 16,
  localparam int DW = CW + 1,
  localparam int MW = 2 * CW + 1,
  localparam int XW = MW + 1,
  localparam int SQW = 2 * MW,
  localparam int SW = SQW + 2,
  localparam int RW = SW + 2 * F + 6,
  localparam int PW = SW + F + 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             take_i,
  input  logic [NUM_AXES-1:0][CW-1:0]      va_i,
  input  logic [NUM_AXES-1:0][CW-1:0]      vb_i,
  input  logic [NUM_AXES-1:0][CW-1:0]      vc_i,
  output ctl_t                             ctl_o,
  output logic [SW-1:0]                    s_o,
  output logic [NUM_AXES-1:0][RW-1:0]      r_o,
  output logic [NUM_AXES-1:0][PW-1:0]      p_o
);

  localparam int LW = (MW + 1) / 2;
  localparam int HW = MW - LW;
  localparam int NS = 7;

  ctl_t ctl_q [NS];
  ctl_t ctl3_d, ctl_out_d;

  logic [NUM_AXES-1:0][DW-1:0]    d1_d, d1_q, d2_d, d2_q;
  logic [NUM_AXES-1:0][XW-1:0]    pa_d, pa_q, pb_d, pb_q;
  logic [NUM_AXES-1:0][XW-1:0]    x_q;
  logic [NUM_AXES-1:0][MW-1:0]    mag_d, mag_q;
  logic [NUM_AXES-1:0][2*HW-1:0]  hh_q;
  logic [NUM_AXES-1:0][HW+LW-1:0] hl_q;
  logic [NUM_AXES-1:0][2*LW-1:0]  ll_q;
  logic [NUM_AXES-1:0][SQW-1:0]   sq_d, sq_q, sqd_q;
  logic [SW-1:0]                  s_q;
  ctl_t                           ctl_out_q;
  logic [SW-1:0]                  s_out_q;
  logic [NUM_AXES-1:0][RW-1:0]    r_q;
  logic [NUM_AXES-1:0][PW-1:0]    p_q;

  always_comb begin
    logic signed [XW-1:0] ta, tb;
    for (int i = 0; i < NUM_AXES; i++) begin
      d1_d[i] = DW'($signed(va_i[i])) - DW'($signed(vb_i[i]));
      d2_d[i] = DW'($signed(va_i[i])) - DW'($signed(vc_i[i]));
    end
    ta = $signed(d1_q[1]) * $signed(d2_q[2]);
    tb = $signed(d1_q[2]) * $signed(d2_q[1]);
    pa_d[0] = ta;
    pb_d[0] = tb;
    ta = $signed(d2_q[0]) * $signed(d1_q[2]);
    tb = $signed(d2_q[2]) * $signed(d1_q[0]);
    pa_d[1] = ta;
    pb_d[1] = tb;
    ta = $signed(d2_q[1]) * $signed(d1_q[0]);
    tb = $signed(d2_q[0]) * $signed(d1_q[1]);
    pa_d[2] = ta;
    pb_d[2] = tb;
    for (int i = 0; i < NUM_AXES; i++) begin
      mag_d[i] = x_q[i][XW-1] ? MW'(-x_q[i]) : MW'(x_q[i]);
      sq_d[i]  = (SQW'(hh_q[i]) << (2 * LW)) + (SQW'(hl_q[i]) << (LW + 1)) + SQW'(ll_q[i]);
    end
  end

  always_comb begin
    ctl3_d = ctl_q[2];
    for (int i = 0; i < NUM_AXES; i++) ctl3_d.neg[i] = x_q[i][XW-1];
    ctl_out_d            = ctl_q[NS-1];
    ctl_out_d.degenerate = (s_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) ctl_q[j] <= '0;
      ctl_out_q <= '0;
    end else begin
      ctl_q[0] <= '{valid: take_i, degenerate: 1'b0, neg: '0};
      ctl_q[1] <= ctl_q[0];
      ctl_q[2] <= ctl_q[1];
      ctl_q[3] <= ctl3_d;
      for (int j = 4; j < NS; j++) ctl_q[j] <= ctl_q[j-1];
      ctl_out_q <= ctl_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    for (int i = 0; i < NUM_AXES; i++) begin
      x_q[i]  <= pa_q[i] - pb_q[i];
      hh_q[i] <= mag_q[i][MW-1:LW] * mag_q[i][MW-1:LW];
      hl_q[i] <= mag_q[i][MW-1:LW] * mag_q[i][LW-1:0];
      ll_q[i] <= mag_q[i][LW-1:0] * mag_q[i][LW-1:0];
      r_q[i]  <= (RW'(sqd_q[i]) << (2 * F + 2)) - RW'(s_q);
      p_q[i]  <= PW'(0) - PW'(s_q);
    end
    mag_q   <= mag_d;
    sq_q    <= sq_d;
    sqd_q   <= sq_q;
    s_q     <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    s_out_q <= s_q;
  end

  assign ctl_o = ctl_out_q;
  assign s_o   = s_out_q;
  assign r_o   = r_q;
  assign p_o   = p_q;

endmodule

// ----- src/tun_cell.sv -----
// one bit cell of the normalizing divider chain, all three axes
module tun_cell import tun_pkg::*; #(
  parameter int CW = 24,
  parameter int F = 16,
  parameter int K = 16,
  localparam int MW = 2 * CW + 1,
  localparam int SW = 2 * MW + 2,
  localparam int RW = SW + 2 * F + 6,
  localparam int PW = SW + F + 3,
  localparam int NW = F + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ctl_t                        ctl_i,
  input  logic [SW-1:0]               s_i,
  input  logic [NUM_AXES-1:0][RW-1:0] r_i,
  input  logic [NUM_AXES-1:0][PW-1:0] p_i,
  input  logic [NUM_AXES-1:0][NW-1:0] m_i,
  output ctl_t                        ctl_o,
  output logic [SW-1:0]               s_o,
  output logic [NUM_AXES-1:0][RW-1:0] r_o,
  output logic [NUM_AXES-1:0][PW-1:0] p_o,
  output logic [NUM_AXES-1:0][NW-1:0] m_o
);

  ctl_t                        ctl_q;
  logic [SW-1:0]               s_q;
  logic [NUM_AXES-1:0][RW-1:0] r_d, r_q;
  logic [NUM_AXES-1:0][PW-1:0] p_d, p_q;
  logic [NUM_AXES-1:0][NW-1:0] m_d, m_q;

  // trial bit k: residual minus s * 2^(k+2) * (t + 2^k), t = 2m - 1
  always_comb begin
    logic [PW-1:0] q;
    logic [RW-1:0] dec, diff;
    for (int i = 0; i < NUM_AXES; i++) begin
      q    = p_i[i] + (PW'(s_i) << K);
      dec  = RW'($signed(q)) << (K + 2);
      diff = r_i[i] - dec;
      r_d[i] = r_i[i];
      p_d[i] = p_i[i];
      m_d[i] = m_i[i];
      if (!m_i[i][NW-1] && !diff[RW-1]) begin
        r_d[i]    = diff;
        p_d[i]    = p_i[i] + (PW'(s_i) << (K + 1));
        m_d[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_i;
    r_q <= r_d;
    p_q <= p_d;
    m_q <= m_d;
  end

  assign ctl_o = ctl_q;
  assign s_o   = s_q;
  assign r_o   = r_q;
  assign p_o   = p_q;
  assign m_o   = m_q;

endmodule

// ----- src/triangle_unit_normal.sv -----
// triangle unit normal: top level with setup pipeline, divider cell chain and output register
// one triangle per cycle; start is never refused, busy stays low
// each start gives one result strobe on valid_o
// the path runs through eight setup stages, one divider cell per result bit and the output register
// reset clears the beat valid pipeline only; data registers are not reset
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int NORMAL_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_WIDTH-1:0]        ax_i,
  input  logic [COORD_WIDTH-1:0]        ay_i,
  input  logic [COORD_WIDTH-1:0]        az_i,
  input  logic [COORD_WIDTH-1:0]        bx_i,
  input  logic [COORD_WIDTH-1:0]        by_coord_i,
  input  logic [COORD_WIDTH-1:0]        bz_i,
  input  logic [COORD_WIDTH-1:0]        cx_i,
  input  logic [COORD_WIDTH-1:0]        cy_i,
  input  logic [COORD_WIDTH-1:0]        cz_i,
  output logic                          valid_o,
  output logic [NORMAL_FRAC_BITS+1:0]   nx_o,
  output logic [NORMAL_FRAC_BITS+1:0]   ny_o,
  output logic [NORMAL_FRAC_BITS+1:0]   nz_o,
  output logic                          degenerate_o
);

  localparam int MW  = 2 * COORD_WIDTH + 1;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW + 2 * NORMAL_FRAC_BITS + 6;
  localparam int PW  = SW + NORMAL_FRAC_BITS + 3;
  localparam int NW  = NORMAL_FRAC_BITS + 1;
  localparam int OW  = NORMAL_FRAC_BITS + 2;
  localparam int LAT = NORMAL_FRAC_BITS + 10;

  ctl_t                        ctl_c [NW+1];
  logic [SW-1:0]               s_c   [NW+1];
  logic [NUM_AXES-1:0][RW-1:0] r_c   [NW+1];
  logic [NUM_AXES-1:0][PW-1:0] p_c   [NW+1];
  logic [NUM_AXES-1:0][NW-1:0] m_c   [NW+1];

  logic                        valid_q, deg_q;
  logic [NUM_AXES-1:0][OW-1:0] n_d, n_q;

  assign busy = 1'b0;

  tun_setup #(
    .CW (COORD_WIDTH),
    .F  (NORMAL_FRAC_BITS)
  ) u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (start && !busy),
    .va_i   ({az_i, ay_i, ax_i}),
    .vb_i   ({bz_i, by_coord_i, bx_i}),
    .vc_i   ({cz_i, cy_i, cx_i}),
    .ctl_o  (ctl_c[0]),
    .s_o    (s_c[0]),
    .r_o    (r_c[0]),
    .p_o    (p_c[0])
  );

  assign m_c[0] = '0;

  for (genvar j = 0; j < NW; j++) begin : g_cell
    tun_cell #(
      .CW (COORD_WIDTH),
      .F  (NORMAL_FRAC_BITS),
      .K  (NORMAL_FRAC_BITS - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[j]),
      .s_i    (s_c[j]),
      .r_i    (r_c[j]),
      .p_i    (p_c[j]),
      .m_i    (m_c[j]),
      .ctl_o  (ctl_c[j+1]),
      .s_o    (s_c[j+1]),
      .r_o    (r_c[j+1]),
      .p_o    (p_c[j+1]),
      .m_o    (m_c[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (ctl_c[NW].degenerate) begin
        n_d[i] = '0;
      end else if (ctl_c[NW].neg[i]) begin
        n_d[i] = OW'(0) - OW'(m_c[NW][i]);
      end else begin
        n_d[i] = OW'(m_c[NW][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_c[NW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    deg_q <= ctl_c[NW].degenerate;
  end

  assign valid_o      = valid_q;
  assign nx_o         = n_q[0];
  assign ny_o         = n_q[1];
  assign nz_o         = n_q[2];
  assign degenerate_o = deg_q;

  // every beat in gives exactly one beat out at fixed latency
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result beat without matching start");

  a_beat_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT valid_o)
    else $error("start beat lost");

  // a non degenerate normal has at least one nonzero component
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !degenerate_o) |-> (nx_o != '0 || ny_o != '0 || nz_o != '0))
    else $error("zero normal without degenerate flag");

endmodule
